@@ rtl/rcfd_pkg.sv @@
// Package for the RC link frame decoder: types, codes and constants.
// No dependencies.
package rcfd_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 64;
    localparam int CHANNEL_COUNT_DEF   = 16;
    localparam int RAW_W   = 11;
    localparam int STICK_W = 16;

    localparam logic [7:0] SYNC_BYTE      = 8'hC8;
    localparam logic [7:0] TYPE_RC        = 8'h16;
    localparam logic [7:0] TYPE_STATS     = 8'h14;
    localparam logic [7:0] TYPE_HEARTBEAT = 8'h0B;

    localparam logic [1:0] KIND_RC    = 2'd0;
    localparam logic [1:0] KIND_STATS = 2'd1;
    localparam logic [1:0] KIND_HB    = 2'd2;

    localparam logic [2:0] REG_STICK_MIN    = 3'd0;
    localparam logic [2:0] REG_STICK_CENTER = 3'd1;
    localparam logic [2:0] REG_MAX_SHORT    = 3'd2;
    localparam logic [2:0] REG_MAX_LONG     = 3'd3;
    localparam logic [2:0] REG_TOGGLE       = 3'd4;
    localparam logic [2:0] REG_UP_CODE      = 3'd5;
    localparam logic [2:0] REG_MID_CODE     = 3'd6;

    localparam logic signed [STICK_W-1:0] Q8_FULL = 16'sd25600;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_LEN,
        ST_BODY,
        ST_FETCH,
        ST_CALC,
        ST_DIV,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic store_len;
        logic write_byte;
        logic start_item;
        logic load_byte;
        logic div_start;
        logic div_step;
        logic finish_item;
        logic next_item;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic frame_ok;
        logic fetch_done;
        logic need_div;
        logic div_done;
        logic last_item;
        logic body_done;
    } status_t;

endpackage

@@ rtl/rc_link_frame_decoder.sv @@
// RC link frame decoder: one byte accepted per cycle while collecting a frame.
// After the last byte each RC channel result reads three store bytes, then sets up
// and registers; a statistics or heartbeat result reads one byte instead; a
// mapped stick on channels 0-3 also runs the serial divider. Input stalls through the emit,
// which any m_tready stall lengthens. Synchronous active-low reset: hunting for
// sync, config at reset values, output empty.
module rc_link_frame_decoder #(
    parameter int MAX_FRAME_BYTES = rcfd_pkg::MAX_FRAME_BYTES_DEF,
    parameter int CHANNEL_COUNT   = rcfd_pkg::CHANNEL_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,      // [3:0] item_index, [14:4] raw_value,
                                      // [30:15] stick_position, [32:31] switch_position
    output logic [1:0]  m_tuser,      // [1:0] frame_kind
    output logic        m_tlast,      // last_of_frame
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    rcfd_pkg::cmd_t    cmd;
    rcfd_pkg::status_t status;
    logic              len_ok, out_free, in_beat;
    logic [3:0]        out_index;
    logic [10:0]       out_raw;
    logic signed [15:0] out_stick;
    logic [1:0]        out_switch;

    assign in_beat   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    rcfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_beat  (in_beat),
        .in_byte  (s_tdata),
        .len_ok   (len_ok),
        .out_free (out_free),
        .status   (status),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    rcfd_datapath #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .CHANNEL_COUNT   (CHANNEL_COUNT)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_byte    (s_tdata),
        .cmd        (cmd),
        .cfg_we     (cfg_valid),
        .cfg_idx    (cfg_index),
        .cfg_data   (cfg_data),
        .out_take   (m_tvalid && m_tready),
        .len_ok     (len_ok),
        .out_free   (out_free),
        .status     (status),
        .out_valid  (m_tvalid),
        .out_kind   (m_tuser),
        .out_index  (out_index),
        .out_raw    (out_raw),
        .out_stick  (out_stick),
        .out_switch (out_switch),
        .out_last   (m_tlast)
    );

    assign m_tdata = {7'd0, out_switch, out_stick, out_raw, out_index};

`ifndef SYNTHESIS
    a_no_input_while_emitting: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_byte || cmd.div_step) |-> !s_tready)
        else $error("input accepted during emit");
    a_finish_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish_item |-> out_free)
        else $error("result overwrote a pending beat");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");
`endif

endmodule

@@ rtl/rcfd_ctrl.sv @@
// Controller state machine of the RC link frame decoder.
// Depends on rcfd_pkg.
module rcfd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_beat,
    input  logic [7:0]        in_byte,
    input  logic              len_ok,
    input  logic              out_free,
    input  rcfd_pkg::status_t status,
    output logic              in_ready,
    output rcfd_pkg::cmd_t    cmd
);

    rcfd_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rcfd_pkg::ST_HUNT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            rcfd_pkg::ST_HUNT: begin
                in_ready = 1'b1;
                if (in_beat && in_byte == rcfd_pkg::SYNC_BYTE) begin
                    state_next = rcfd_pkg::ST_LEN;
                end
            end
            rcfd_pkg::ST_LEN: begin
                in_ready = 1'b1;
                if (in_beat) begin
                    if (len_ok) begin
                        cmd.store_len = 1'b1;
                        state_next    = rcfd_pkg::ST_BODY;
                    end else if (in_byte != rcfd_pkg::SYNC_BYTE) begin
                        state_next = rcfd_pkg::ST_HUNT;
                    end
                end
            end
            rcfd_pkg::ST_BODY: begin
                in_ready = 1'b1;
                if (in_beat) begin
                    cmd.write_byte = 1'b1;
                    if (status.body_done) begin
                        state_next = rcfd_pkg::ST_HUNT;
                    end
                end
            end
            rcfd_pkg::ST_FETCH: begin
                cmd.load_byte = 1'b1;
                if (status.fetch_done) begin
                    state_next = rcfd_pkg::ST_CALC;
                end
            end
            rcfd_pkg::ST_CALC: begin
                if (status.need_div) begin
                    cmd.div_start = 1'b1;
                    state_next    = rcfd_pkg::ST_DIV;
                end else if (out_free) begin
                    cmd.finish_item = 1'b1;
                    state_next      = rcfd_pkg::ST_OUT;
                end
            end
            rcfd_pkg::ST_DIV: begin
                if (status.div_done) begin
                    if (out_free) begin
                        cmd.finish_item = 1'b1;
                        state_next      = rcfd_pkg::ST_OUT;
                    end
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            rcfd_pkg::ST_OUT: begin
                if (status.last_item) begin
                    state_next = rcfd_pkg::ST_HUNT;
                end else begin
                    cmd.next_item  = 1'b1;
                    cmd.start_item = 1'b1;
                    state_next     = rcfd_pkg::ST_FETCH;
                end
            end
            default: state_next = rcfd_pkg::ST_HUNT;
        endcase
        // a complete, decodable frame goes to the emit loop
        if (state_reg == rcfd_pkg::ST_BODY && in_beat && status.body_done &&
            status.frame_ok) begin
            cmd.start_item = 1'b1;
            state_next     = rcfd_pkg::ST_FETCH;
        end
    end

endmodule

@@ rtl/rcfd_datapath.sv @@
// Datapath of the RC link frame decoder: frame store, channel unpack,
// stick mapping with a serial divider, switch decode and output register.
// Depends on rcfd_pkg.
module rcfd_datapath #(
    parameter int MAX_FRAME_BYTES = rcfd_pkg::MAX_FRAME_BYTES_DEF,
    parameter int CHANNEL_COUNT   = rcfd_pkg::CHANNEL_COUNT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [7:0]                  in_byte,
    input  rcfd_pkg::cmd_t              cmd,
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_idx,
    input  logic [10:0]                 cfg_data,
    input  logic                        out_take,
    output logic                        len_ok,
    output logic                        out_free,
    output rcfd_pkg::status_t           status,
    output logic                        out_valid,
    output logic [1:0]                  out_kind,
    output logic [3:0]                  out_index,
    output logic [10:0]                 out_raw,
    output logic signed [15:0]          out_stick,
    output logic [1:0]                  out_switch,
    output logic                        out_last
);

    localparam int AW = $clog2(MAX_FRAME_BYTES);
    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CW = $clog2(CHANNEL_COUNT);

    logic [10:0] stick_min_reg, stick_center_reg, max_short_reg, max_long_reg;
    logic [10:0] toggle_reg, up_code_reg, mid_code_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stick_min_reg    <= 11'd174;
            stick_center_reg <= 11'd992;
            max_short_reg    <= 11'd1808;
            max_long_reg     <= 11'd1811;
            toggle_reg       <= 11'd1000;
            up_code_reg      <= 11'd191;
            mid_code_reg     <= 11'd997;
        end else if (cfg_we) begin
            case (cfg_idx)
                rcfd_pkg::REG_STICK_MIN:    stick_min_reg    <= cfg_data;
                rcfd_pkg::REG_STICK_CENTER: stick_center_reg <= cfg_data;
                rcfd_pkg::REG_MAX_SHORT:    max_short_reg    <= cfg_data;
                rcfd_pkg::REG_MAX_LONG:     max_long_reg     <= cfg_data;
                rcfd_pkg::REG_TOGGLE:       toggle_reg       <= cfg_data;
                rcfd_pkg::REG_UP_CODE:      up_code_reg      <= cfg_data;
                rcfd_pkg::REG_MID_CODE:     mid_code_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // frame collection
    logic [7:0]    len_reg;
    logic [PW-1:0] pos_reg;
    logic [7:0]    type_reg;
    logic [7:0]    store_mem [MAX_FRAME_BYTES];
    logic [8:0]    len_plus2;

    assign len_plus2 = {1'b0, in_byte} + 9'd2;
    assign len_ok    = (in_byte != 8'd0) && (len_plus2 <= 9'(MAX_FRAME_BYTES));

    logic [7:0] plen;
    logic [8:0] pos_inc;
    assign pos_inc = 9'(pos_reg) + 9'd1;
    assign plen    = (len_reg >= 8'd2) ? len_reg - 8'd2 : 8'd0;
    assign status.body_done = pos_inc >= {1'b0, len_reg};

    logic [7:0] type_now;
    assign type_now = (pos_reg == '0) ? in_byte : type_reg;
    assign status.frame_ok = (type_now == rcfd_pkg::TYPE_RC && plen >= 8'd22) ||
                             (type_now == rcfd_pkg::TYPE_STATS && plen >= 8'd10) ||
                             (type_now == rcfd_pkg::TYPE_HEARTBEAT && plen >= 8'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= '0;
            pos_reg  <= '0;
            type_reg <= '0;
        end else if (cmd.store_len) begin
            len_reg <= in_byte;
            pos_reg <= '0;
        end else if (cmd.write_byte) begin
            if (pos_reg == '0) type_reg <= in_byte;
            pos_reg <= status.body_done ? '0 : PW'(pos_inc);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_byte) begin
            store_mem[pos_reg[AW-1:0]] <= in_byte;
        end
    end

    // item loop: fetch three payload bytes for an RC channel or one otherwise, one per cycle
    logic [CW-1:0] item_reg;
    logic [1:0]    fcnt_reg;
    logic [23:0]   word_reg;
    logic [7:0]    rd_reg;
    logic          rd_ok_reg;
    logic [1:0]    kind;
    logic [8:0]    base_byte;
    logic [9:0]    rd_addr;
    logic [2:0]    fetch_n;

    assign kind = (type_reg == rcfd_pkg::TYPE_RC) ? rcfd_pkg::KIND_RC :
                  (type_reg == rcfd_pkg::TYPE_STATS) ? rcfd_pkg::KIND_STATS :
                  rcfd_pkg::KIND_HB;
    assign base_byte = (kind == rcfd_pkg::KIND_RC) ?
                       9'(({5'd0, item_reg} * 9'd11) >> 3) : 9'(item_reg);
    assign rd_addr = 10'(base_byte) + 10'(fcnt_reg) + 10'd1;
    assign fetch_n = (kind == rcfd_pkg::KIND_RC) ? 3'd3 : 3'd1;

    // registered memory read; fcnt counts issued reads, got_reg the bytes captured from the read register
    logic [1:0] got_reg;
    always_ff @(posedge aclk) begin
        rd_reg    <= store_mem[rd_addr[AW-1:0]];
        rd_ok_reg <= rd_addr < 10'(MAX_FRAME_BYTES);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg <= '0;
            fcnt_reg <= '0;
            got_reg  <= '0;
        end else if (cmd.start_item) begin
            if (!cmd.next_item) item_reg <= '0;
            else item_reg <= item_reg + CW'(1);
            fcnt_reg <= '0;
            got_reg  <= '0;
        end else if (cmd.load_byte) begin
            if (3'(fcnt_reg) < fetch_n) fcnt_reg <= fcnt_reg + 2'd1;
            if (fcnt_reg != 2'd0 && 3'(got_reg) < fetch_n) begin
                got_reg <= got_reg + 2'd1;
                word_reg[8*got_reg +: 8] <= rd_ok_reg ? rd_reg : 8'd0;
            end
        end
    end
    assign status.fetch_done = (3'(got_reg) == fetch_n);

    logic [3:0]  sh;
    logic [10:0] raw;
    assign sh  = 4'(({5'd0, item_reg} * 9'd11) & 9'd7);
    assign raw = (kind == rcfd_pkg::KIND_RC) ? 11'(word_reg >> sh) : {3'd0, word_reg[7:0]};

    // stick mapping setup
    logic [10:0] hi;
    logic        stick_ch, degen, below;
    logic [10:0] num, den;
    assign stick_ch = (kind == rcfd_pkg::KIND_RC) && (item_reg < CW'(4));
    assign hi    = item_reg[0] ? max_short_reg : max_long_reg;
    assign degen = stick_min_reg >= hi || stick_center_reg <= stick_min_reg ||
                   stick_center_reg >= hi;
    assign below = raw < stick_center_reg;
    assign num   = below ? raw - stick_min_reg : raw - stick_center_reg;
    assign den   = below ? stick_center_reg - stick_min_reg : hi - stick_center_reg;
    assign status.need_div = stick_ch && !degen &&
                             !(below && raw < stick_min_reg) && !(!below && raw > hi);

    // restoring divider, one quotient bit per cycle
    logic [25:0] dividend_reg;
    logic [10:0] den_reg;
    logic [11:0] rem_reg;
    logic [4:0]  dcnt_reg;
    logic [15:0] quo_reg;
    logic        below_reg;
    logic [12:0] rem_sh;
    logic [12:0] rem_try;

    assign rem_sh  = {rem_reg, dividend_reg[25]};
    assign rem_try = rem_sh - {2'd0, den_reg};
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
        end else if (cmd.div_start) begin
            dividend_reg <= 26'(num) * 26'd25600 + 26'(den >> 1);
            den_reg      <= den;
            rem_reg      <= '0;
            quo_reg      <= '0;
            below_reg    <= below;
            dcnt_reg     <= 5'd26;
        end else if (cmd.div_step) begin
            dividend_reg <= dividend_reg << 1;
            if (!rem_try[12]) begin
                rem_reg <= rem_try[11:0];
                quo_reg <= {quo_reg[14:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[11:0];
                quo_reg <= {quo_reg[14:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg - 5'd1;
        end
    end
    assign status.div_done = (dcnt_reg == 5'd0);

    logic signed [15:0] stick_val;
    always_comb begin
        if (!stick_ch) stick_val = '0;
        else if (degen) stick_val = -rcfd_pkg::Q8_FULL;
        else if (below && raw < stick_min_reg) stick_val = -rcfd_pkg::Q8_FULL;
        else if (!below && raw > hi) stick_val = rcfd_pkg::Q8_FULL;
        else if (below_reg) stick_val = $signed(quo_reg) - rcfd_pkg::Q8_FULL;
        else stick_val = $signed(quo_reg);
    end

    logic [1:0] sw_val;
    always_comb begin
        sw_val = 2'd0;
        if (kind == rcfd_pkg::KIND_RC && item_reg >= CW'(4) && item_reg < CW'(8)) begin
            sw_val = (raw == up_code_reg) ? 2'd1 : ((raw == mid_code_reg) ? 2'd0 : 2'd2);
        end else if (kind == rcfd_pkg::KIND_RC && item_reg >= CW'(8) &&
                     item_reg < CW'(10)) begin
            sw_val = (raw > toggle_reg) ? 2'd1 : 2'd0;
        end
    end

    logic last_now;
    assign last_now = (kind == rcfd_pkg::KIND_RC) ? (item_reg == CW'(CHANNEL_COUNT - 1)) :
                      (kind == rcfd_pkg::KIND_STATS) ? (item_reg == CW'(9)) : 1'b1;
    assign status.last_item = out_last;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (cmd.finish_item) begin
            out_valid <= 1'b1;
        end else if (out_take) begin
            out_valid <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (cmd.finish_item) begin
            out_kind   <= kind;
            out_index  <= 4'(item_reg);
            out_raw    <= raw;
            out_stick  <= stick_val;
            out_switch <= sw_val;
            out_last   <= last_now;
        end
    end
    assign out_free = !out_valid || out_take;

endmodule
